// File: src/region_binned_histogram_assert.svh
// Assertion macros shared by the region histogram RTL.
`ifndef REGION_BINNED_HISTOGRAM_ASSERT_SVH
`define REGION_BINNED_HISTOGRAM_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define RBH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbh: same-cycle check failed");
// next-cycle implication
`define RBH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbh: next-cycle check failed");
`else
`define RBH_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RBH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: src/rbh_pkg.sv
// Types and constants of the region histogram.
package rbh_pkg;

   // binning geometry
   localparam int RadiusBins   = 99;
   localparam int ZBins        = 6;
   localparam int RadiusStep   = 1600;
   localparam int SensorPixels = 104652;

   // field widths
   localparam int CoordW = 19;
   localparam int ZW     = 20;
   localparam int PixW   = 32;
   localparam int OpW    = 2;
   localparam int RzbW   = 3;
   localparam int RrbW   = 7;
   localparam int CountW = 16;
   localparam int SumW   = 48;
   localparam int AvgW   = 32;
   localparam int WordW  = CountW + SumW;

   // region store
   localparam int StoreDepth = RadiusBins * ZBins;
   localparam int AddrW      = $clog2(StoreDepth);

   // radius bin by reciprocal multiply: exact for d < RadLimit
   localparam int RadLimit   = RadiusBins * RadiusStep;
   localparam int RadDW      = (RadLimit > 1) ? $clog2(RadLimit) : 1;
   localparam int StepLog    = $clog2(RadiusStep);
   localparam int RecipShift = RadDW + StepLog;
   localparam longint unsigned RecipMul =
      ((64'd1 << RecipShift) + 64'(RadiusStep) - 64'd1) / 64'(RadiusStep);
   localparam int RecipW     = $clog2(RecipMul + 1);
   localparam int ProdW      = RadDW + RecipW;
   localparam int RbW        = (RadiusBins > 1) ? $clog2(RadiusBins) : 1;
   localparam int KW         = (ZBins > 1) ? $clog2(ZBins) : 1;

   // average divider
   localparam int PixCntW  = $clog2(SensorPixels + 1);
   localparam int DivW     = CountW + PixCntW;
   localparam int StepCntW = $clog2(SumW);
   localparam logic [SumW-1:0] QuotPosMax = SumW'((64'd1 << (AvgW - 1)) - 64'd1);
   localparam logic [SumW-1:0] QuotNegMax = SumW'(64'd1 << (AvgW - 1));
   localparam logic [AvgW-1:0] AvgMax = {1'b0, {(AvgW-1){1'b1}}};
   localparam logic [AvgW-1:0] AvgMin = {1'b1, {(AvgW-1){1'b0}}};
   localparam logic [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
   localparam logic [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

   // configuration registers
   localparam int NumZEdges = 7;
   localparam int NumCfg    = 8;
   localparam int CsrAW     = $clog2(NumCfg * 4);
   localparam int CfgIdxW   = $clog2(NumCfg);
   localparam int CsrDW     = 32;
   localparam logic [CfgIdxW-1:0] CfgRadiusOrigin = CfgIdxW'(7);
   localparam logic [CoordW-1:0] ZEdgeReset [NumZEdges] = '{
      19'd96000, 19'd128000, 19'd168000, 19'd192000,
      19'd272000, 19'd320000, 19'd400000
   };
   localparam logic [CoordW-1:0] RadiusOriginReset = 19'd32000;

   // opcodes
   localparam logic [OpW-1:0] OpTally = 2'd0;
   localparam logic [OpW-1:0] OpAdd   = 2'd1;
   localparam logic [OpW-1:0] OpRead  = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_SCAN,
      ST_MODIFY,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_DIVIDE,
      ST_FINISH,
      ST_RESPOND
   } state_type;

endpackage

// File: src/rbh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbh_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/region_binned_histogram.sv
// Top level of the (radius, |z|) region histogram accumulator.
//
// Accumulates sensor tallies and signed pixel sums into a grid of 99 radius
// bins by 6 |z| bins, held as {count, sum} words in one 594-entry RAM with a
// registered read. A tally or add beat finds its radius bin with a reciprocal
// multiply, marks every z bin whose edges contain |z|, then walks the z bins
// one per cycle, pausing for a read-modify-write on each hit; the next beat
// is taken only once the walk ends (or the prep step, when the radius is out
// of range or no region is hit), set by the single RAM port pair and the
// sequential z walk, so no two accesses to an entry ever overlap. A read beat
// runs the 48-step restoring divider that forms sum / (count * pixels per
// sensor); a read of an empty region skips the divider, and a read with a
// bin index out of range skips the RAM read and divider and answers with
// read_status set. The response sits in an output register, so new beats are
// accepted while it waits for rsp_ready; a second read waits in its respond
// step with req_ready low until that register frees up. After reset a
// clearing pass writes zero to all 594 entries, one per cycle, with
// req_ready low; CSR writes are taken during it. Count saturates at 65535,
// sum clamps to 48-bit signed, average clamps to 32-bit signed.
`include "region_binned_histogram_assert.svh"

module region_binned_histogram (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rbh_pkg::OpW-1:0]             req_opcode,
   input  logic [rbh_pkg::CoordW-1:0]          req_radius_pos,
   input  logic signed [rbh_pkg::ZW-1:0]       req_z_pos,
   input  logic signed [rbh_pkg::PixW-1:0]     req_pixel_value,
   input  logic [rbh_pkg::RzbW-1:0]            req_read_z_bin,
   input  logic [rbh_pkg::RrbW-1:0]            req_read_radius_bin,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_read_status,
   output logic [rbh_pkg::CountW-1:0]          rsp_region_count,
   output logic signed [rbh_pkg::SumW-1:0]     rsp_region_sum,
   output logic signed [rbh_pkg::AvgW-1:0]     rsp_region_average,
   // CSR port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rbh_pkg::CsrAW-1:0]           csr_paddr,
   input  logic [rbh_pkg::CsrDW-1:0]           csr_pwdata,
   output logic [rbh_pkg::CsrDW-1:0]           csr_prdata,
   output logic                                csr_pready
);

   import rbh_pkg::*;

   // control state
   state_type          state_ff, state_in;
   logic [AddrW-1:0]   clr_addr_ff, clr_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // CSRs
   logic [CoordW-1:0]  z_edge_ff [NumZEdges];
   logic [CoordW-1:0]  radius_origin_ff;
   logic               csr_write;
   logic [CfgIdxW-1:0] csr_idx;

   // captured request beat
   logic [OpW-1:0]          op_ff;
   logic [CoordW-1:0]       radius_ff;
   logic signed [ZW-1:0]    z_ff;
   logic signed [PixW-1:0]  pix_ff;
   logic [RzbW-1:0]         rzb_ff;
   logic [RrbW-1:0]         rrb_ff;
   logic                    req_take;

   // accumulate path
   logic [RadDW-1:0]   d_ff, d_in;
   logic [ZBins-1:0]   hit_ff, hit_in;
   logic [AddrW-1:0]   base_ff, base_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [CoordW-1:0]  rad_diff;
   logic               rad_in_range;
   logic [ZW-1:0]      z_mag;
   logic [ZBins-1:0]   hit_w;
   logic [ProdW-1:0]   prod_w;
   logic [RbW-1:0]     rb_w;
   logic [CountW-1:0]  cnt_old, cnt_new;
   logic [SumW-1:0]    sum_old, sum_sat;
   logic [SumW:0]      sum_ext;
   logic               k_last;

   // read / divide path
   logic               res_status_ff, res_status_in;
   logic [CountW-1:0]  res_count_ff, res_count_in;
   logic [SumW-1:0]    res_sum_ff, res_sum_in;
   logic [AvgW-1:0]    res_avg_ff, res_avg_in;
   logic [DivW-1:0]    divisor_ff, divisor_in;
   logic [SumW-1:0]    dq_ff, dq_in;
   logic [DivW-1:0]    rem_ff, rem_in;
   logic [StepCntW-1:0] step_ff, step_in;
   logic [DivW:0]      trial;
   logic               trial_ge;
   logic               rd_out_of_range;
   logic [AddrW-1:0]   rd_idx;

   // output register
   logic               rsp_load;
   logic               rsp_status_ff;
   logic [CountW-1:0]  rsp_count_ff;
   logic [SumW-1:0]    rsp_sum_ff;
   logic [AvgW-1:0]    rsp_avg_ff;

   // RAM port
   logic               ram_wr_en;
   logic [AddrW-1:0]   ram_wr_addr;
   logic [WordW-1:0]   ram_wr_data;
   logic               ram_rd_en;
   logic [AddrW-1:0]   ram_rd_addr;
   logic [WordW-1:0]   ram_rd_data;

   rbh_ram #(
      .Width (WordW),
      .Depth (StoreDepth)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- CSRs
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CsrAW-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumZEdges; i++) begin
            z_edge_ff[i] <= ZEdgeReset[i];
         end
         radius_origin_ff <= RadiusOriginReset;
      end else if (csr_write) begin
         if (csr_idx == CfgRadiusOrigin) begin
            radius_origin_ff <= csr_pwdata[CoordW-1:0];
         end else begin
            z_edge_ff[csr_idx] <= csr_pwdata[CoordW-1:0];
         end
      end
   end

   always_comb begin
      if (csr_idx == CfgRadiusOrigin) begin
         csr_prdata = CsrDW'(radius_origin_ff);
      end else begin
         csr_prdata = CsrDW'(z_edge_ff[csr_idx]);
      end
   end

   // ---------------------------------------------------- datapath helpers
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   // radius: lower edge excluded, upper edge included
   assign rad_diff     = radius_ff - radius_origin_ff - CoordW'(1);
   assign rad_in_range = (radius_ff > radius_origin_ff) &&
                         (32'(rad_diff) < 32'(RadLimit));
   assign z_mag        = z_ff[ZW-1] ? ZW'(-z_ff) : ZW'(z_ff);

   always_comb begin
      for (int k = 0; k < ZBins; k++) begin
         hit_w[k] = (z_mag > {1'b0, z_edge_ff[k]}) &&
                    (z_mag <= {1'b0, z_edge_ff[k+1]});
      end
   end

   assign prod_w = ProdW'(d_ff) * ProdW'(RecipMul);
   assign rb_w   = RbW'(prod_w >> RecipShift);

   // saturating read-modify-write values
   assign cnt_old = ram_rd_data[WordW-1 -: CountW];
   assign sum_old = ram_rd_data[SumW-1:0];
   assign cnt_new = (cnt_old == {CountW{1'b1}}) ? cnt_old : cnt_old + CountW'(1);
   assign sum_ext = {sum_old[SumW-1], sum_old} +
                    {{(SumW+1-PixW){pix_ff[PixW-1]}}, pix_ff};
   always_comb begin
      if (sum_ext[SumW] != sum_ext[SumW-1]) begin
         sum_sat = sum_ext[SumW] ? SumMin : SumMax;
      end else begin
         sum_sat = sum_ext[SumW-1:0];
      end
   end
   assign k_last = (k_ff == KW'(ZBins - 1));

   assign rd_out_of_range = (32'(rzb_ff) >= ZBins) || (32'(rrb_ff) >= RadiusBins);
   assign rd_idx = AddrW'(32'(rzb_ff) * RadiusBins + 32'(rrb_ff));

   // one restoring division step
   assign trial    = {rem_ff, dq_ff[SumW-1]};
   assign trial_ge = (trial >= {1'b0, divisor_ff});

   // ------------------------------------------------------ state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff     <= req_opcode;
         radius_ff <= req_radius_pos;
         z_ff      <= req_z_pos;
         pix_ff    <= req_pixel_value;
         rzb_ff    <= req_read_z_bin;
         rrb_ff    <= req_read_radius_bin;
      end
      d_ff          <= d_in;
      hit_ff        <= hit_in;
      base_ff       <= base_in;
      k_ff          <= k_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      res_sum_ff    <= res_sum_in;
      res_avg_ff    <= res_avg_in;
      divisor_ff    <= divisor_in;
      dq_ff         <= dq_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= res_count_ff;
         rsp_sum_ff    <= res_sum_ff;
         rsp_avg_ff    <= res_avg_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      d_in          = d_ff;
      hit_in        = hit_ff;
      base_in       = base_ff;
      k_in          = k_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      res_sum_in    = res_sum_ff;
      res_avg_in    = res_avg_ff;
      divisor_in    = divisor_ff;
      dq_in         = dq_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      rsp_load      = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = base_ff;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = base_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AddrW'(1);
            if (clr_addr_ff == AddrW'(StoreDepth - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_opcode) inside
                  OpTally, OpAdd: state_in = ST_PREP;
                  OpRead:         state_in = ST_RD_ADDR;
                  default:        state_in = ST_IDLE;
               endcase
            end
         end

         // radius offset and z bin hit mask
         ST_PREP: begin
            d_in   = RadDW'(rad_diff);
            hit_in = hit_w;
            if (rad_in_range && (hit_w != '0)) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_MUL: begin
            base_in  = AddrW'(rb_w);
            k_in     = '0;
            state_in = ST_SCAN;
         end

         // walk the z bins; a hit reads its entry
         ST_SCAN: begin
            if (hit_ff[k_ff]) begin
               ram_rd_en = 1'b1;
               state_in  = ST_MODIFY;
            end else if (k_last) begin
               state_in = ST_IDLE;
            end else begin
               k_in    = k_ff + KW'(1);
               base_in = base_ff + AddrW'(RadiusBins);
            end
         end

         ST_MODIFY: begin
            ram_wr_en = 1'b1;
            if (op_ff == OpTally) begin
               ram_wr_data = {cnt_new, sum_old};
            end else begin
               ram_wr_data = {cnt_old, sum_sat};
            end
            if (k_last) begin
               state_in = ST_IDLE;
            end else begin
               k_in     = k_ff + KW'(1);
               base_in  = base_ff + AddrW'(RadiusBins);
               state_in = ST_SCAN;
            end
         end

         ST_RD_ADDR: begin
            if (rd_out_of_range) begin
               res_status_in = 1'b1;
               res_count_in  = '0;
               res_sum_in    = '0;
               res_avg_in    = '0;
               state_in      = ST_RESPOND;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rd_idx;
               state_in    = ST_RD_DATA;
            end
         end

         ST_RD_DATA: begin
            res_status_in = 1'b0;
            res_count_in  = cnt_old;
            res_sum_in    = sum_old;
            res_avg_in    = '0;
            divisor_in    = DivW'(cnt_old) * DivW'(SensorPixels);
            dq_in         = sum_old[SumW-1] ? SumW'(-sum_old) : sum_old;
            rem_in        = '0;
            step_in       = '0;
            if (cnt_old == '0) begin
               state_in = ST_RESPOND;
            end else begin
               state_in = ST_DIVIDE;
            end
         end

         // one quotient bit per cycle, MSB first
         ST_DIVIDE: begin
            if (trial_ge) begin
               rem_in = DivW'(trial - {1'b0, divisor_ff});
            end else begin
               rem_in = DivW'(trial);
            end
            dq_in   = {dq_ff[SumW-2:0], trial_ge};
            step_in = step_ff + StepCntW'(1);
            if (step_ff == StepCntW'(SumW - 1)) begin
               state_in = ST_FINISH;
            end
         end

         // sign and clamp the quotient
         ST_FINISH: begin
            if (res_sum_ff[SumW-1]) begin
               res_avg_in = (dq_ff > QuotNegMax) ? AvgMin : -(AvgW'(dq_ff));
            end else begin
               res_avg_in = (dq_ff > QuotPosMax) ? AvgMax : AvgW'(dq_ff);
            end
            state_in = ST_RESPOND;
         end

         ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: holds until the beat is taken
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_status    = rsp_status_ff;
   assign rsp_region_count   = rsp_count_ff;
   assign rsp_region_sum     = rsp_sum_ff;
   assign rsp_region_average = rsp_avg_ff;

   // ---------------------------------------------------------- assertions
   // every write-back follows the read of its entry
   `RBH_ASSERT_IMPLY(a_modify_after_scan, clock, reset, state_ff == ST_MODIFY, $past(state_ff) == ST_SCAN)
   // divider remainder stays below the divisor
   `RBH_ASSERT_IMPLY(a_rem_below_div, clock, reset, state_ff == ST_DIVIDE, rem_ff < divisor_ff)
   // a response appears only out of the respond state
   `RBH_ASSERT_IMPLY(a_rsp_from_respond, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_RESPOND)
   // an accepted beat always starts work or is dropped
   `RBH_ASSERT_NEXT(a_take_moves_on, clock, reset, req_take, state_ff == ST_PREP || state_ff == ST_RD_ADDR || state_ff == ST_IDLE)

endmodule
